FILE: sv/ial_pkg.sv
`timescale 1ns / 1ps

package ial_pkg;

  localparam int DEPTH  = 64;
  localparam int AW     = $clog2(DEPTH);
  localparam int CNT_W  = 7;
  localparam int REQ_W  = 4;
  localparam int POS_W  = 7;
  localparam int DATA_W = 32;

  localparam logic [REQ_W-1:0] REQ_INSERT_AT    = 4'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT_FRONT = 4'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT_BACK  = 4'd2;
  localparam logic [REQ_W-1:0] REQ_REMOVE_AT    = 4'd3;
  localparam logic [REQ_W-1:0] REQ_REMOVE_FRONT = 4'd4;
  localparam logic [REQ_W-1:0] REQ_REMOVE_BACK  = 4'd5;
  localparam logic [REQ_W-1:0] REQ_SEARCH       = 4'd6;
  localparam logic [REQ_W-1:0] REQ_READ         = 4'd7;
  localparam logic [REQ_W-1:0] REQ_OVERWRITE    = 4'd8;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INS,
    OP_REM,
    OP_SRCH,
    OP_READ,
    OP_OVWR
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_RD_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic wr_en;
    logic wr_item;
    logic idx_step;
    logic cnt_inc;
    logic cnt_dec;
    logic cap_read;
    logic cap_found;
    logic out_load;
  } ial_cmd_t;

  typedef struct packed {
    op_t  op;
    logic ok;
    logic more;
    logic hit;
    logic empty;
    logic out_free;
  } ial_sts_t;

endpackage

FILE: sv/ial_req_if.sv
`timescale 1ns / 1ps

interface ial_req_if import ial_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] item_value;

  modport source (output valid, req_type, position, item_value, input ready);
  modport sink   (input valid, req_type, position, item_value, output ready);
endinterface

FILE: sv/ial_rsp_if.sv
`timescale 1ns / 1ps

interface ial_rsp_if import ial_pkg::*; ;
  logic              valid;
  logic              ready;
  logic              ok;
  logic [DATA_W-1:0] read_value;
  logic [POS_W-1:0]  found_position;
  logic [CNT_W-1:0]  count;
  logic              is_empty;
  logic              is_full;

  modport source (output valid, ok, read_value, found_position, count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, ok, read_value, found_position, count, is_empty, is_full,
                  output ready);
endinterface

FILE: sv/ial_ram.sv
`timescale 1ns / 1ps

module ial_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/ial_datapath.sv
`timescale 1ns / 1ps

module ial_datapath import ial_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  ial_cmd_t          cmd,
  output ial_sts_t          sts,
  input  logic [REQ_W-1:0]  req_type,
  input  logic [POS_W-1:0]  position,
  input  logic [DATA_W-1:0] item_value,
  ial_rsp_if.source         rsp
);

  logic [CNT_W-1:0]  count;
  op_t               op;
  logic              ok;
  logic [POS_W-1:0]  epos;
  logic [DATA_W-1:0] val;
  logic [CNT_W-1:0]  idx;
  logic [DATA_W-1:0] rd_val;
  logic [POS_W-1:0]  found;

  logic              out_valid;
  logic              out_ok;
  logic [DATA_W-1:0] out_read;
  logic [POS_W-1:0]  out_found;
  logic [CNT_W-1:0]  out_count;
  logic              out_empty;
  logic              out_full;

  op_t               op_in;
  logic [POS_W-1:0]  epos_in;
  logic              ok_in;
  logic [CNT_W-1:0]  idx_in;
  logic [CNT_W-1:0]  idx_up;
  logic [CNT_W-1:0]  idx_dn;
  logic [CNT_W-1:0]  rd_addr_w;
  logic [DATA_W-1:0] ram_rdata;
  logic              full_now;
  logic              more;

  assign full_now = (count == CNT_W'(DEPTH));
  assign idx_up   = idx + CNT_W'(1);
  assign idx_dn   = idx - CNT_W'(1);

  // decode of the incoming request against the current count
  always_comb begin
    op_in   = OP_NOP;
    epos_in = '0;
    unique case (req_type)
      REQ_INSERT_AT: begin
        op_in   = OP_INS;
        epos_in = position;
      end
      REQ_INSERT_FRONT: op_in = OP_INS;
      REQ_INSERT_BACK: begin
        op_in   = OP_INS;
        epos_in = count;
      end
      REQ_REMOVE_AT: begin
        op_in   = OP_REM;
        epos_in = position;
      end
      REQ_REMOVE_FRONT: op_in = OP_REM;
      REQ_REMOVE_BACK: begin
        op_in   = OP_REM;
        epos_in = count - CNT_W'(1);
      end
      REQ_SEARCH: op_in = OP_SRCH;
      REQ_READ: begin
        op_in   = OP_READ;
        // past the end reads the last entry
        epos_in = (position < count) ? position : count - CNT_W'(1);
      end
      REQ_OVERWRITE: begin
        op_in   = OP_OVWR;
        epos_in = position;
      end
      default: op_in = OP_NOP;
    endcase
  end

  always_comb begin
    ok_in  = 1'b0;
    idx_in = '0;
    unique case (op_in)
      OP_INS: begin
        ok_in  = !full_now && (epos_in <= count);
        idx_in = count;
      end
      OP_REM: begin
        ok_in  = (count != '0) && (epos_in < count);
        idx_in = epos_in;
      end
      OP_OVWR: ok_in = (epos_in < count);
      default: ok_in = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= op_in;
      ok     <= ok_in;
      epos   <= epos_in;
      val    <= item_value;
      idx    <= idx_in;
      rd_val <= '0;
      found  <= '0;
    end else begin
      if (cmd.idx_step) begin
        idx <= (op == OP_INS) ? idx_dn : idx_up;
      end
      if (cmd.cap_read) begin
        rd_val <= ram_rdata;
      end
      if (cmd.cap_found) begin
        found <= idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.cnt_inc) begin
      count <= count + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      count <= count - CNT_W'(1);
    end
  end

  always_comb begin
    unique case (op)
      OP_INS:  rd_addr_w = idx_dn;
      OP_REM:  rd_addr_w = idx_up;
      OP_READ: rd_addr_w = epos;
      default: rd_addr_w = idx;
    endcase
  end

  always_comb begin
    unique case (op)
      OP_INS:  more = (idx > epos);
      OP_REM:  more = (idx_up < count);
      OP_SRCH: more = (idx < count);
      default: more = 1'b0;
    endcase
  end

  ial_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.wr_item ? epos[AW-1:0] : idx[AW-1:0]),
    .wr_data (cmd.wr_item ? val : ram_rdata),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr_w[AW-1:0]),
    .rd_data (ram_rdata)
  );

  assign sts = '{op:       op,
                 ok:       ok,
                 more:     more,
                 hit:      (ram_rdata == val),
                 empty:    (count == '0),
                 out_free: (!out_valid || rsp.ready)};

  // output register, frees the core while the result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok    <= ok;
      out_read  <= rd_val;
      out_found <= found;
      out_count <= count;
      out_empty <= (count == '0);
      out_full  <= full_now;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.ok             = out_ok;
  assign rsp.read_value     = out_read;
  assign rsp.found_position = out_found;
  assign rsp.count          = out_count;
  assign rsp.is_empty       = out_empty;
  assign rsp.is_full        = out_full;

endmodule

FILE: sv/ial_ctrl.sv
`timescale 1ns / 1ps

module ial_ctrl import ial_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  ial_sts_t sts,
  output ial_cmd_t cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_DECODE;
      end
      ST_DECODE: begin
        unique case (sts.op)
          OP_INS, OP_REM: state_next = sts.ok ? ST_SHIFT_RD : ST_FINISH;
          OP_SRCH:        state_next = ST_SRCH_RD;
          OP_READ:        state_next = sts.empty ? ST_FINISH : ST_RD_WAIT;
          OP_OVWR:        state_next = sts.ok ? ST_PUT : ST_FINISH;
          default:        state_next = ST_FINISH;
        endcase
      end
      ST_SHIFT_RD: begin
        if (sts.more)               state_next = ST_SHIFT_WR;
        else if (sts.op == OP_INS)  state_next = ST_PUT;
        else                        state_next = ST_FINISH;
      end
      ST_SHIFT_WR: state_next = ST_SHIFT_RD;
      ST_PUT:      state_next = ST_FINISH;
      ST_SRCH_RD:  state_next = sts.more ? ST_SRCH_CMP : ST_FINISH;
      ST_SRCH_CMP: state_next = sts.hit ? ST_FINISH : ST_SRCH_RD;
      ST_RD_WAIT:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      ST_DECODE: begin
        if (sts.op == OP_READ && !sts.empty) cmd.rd_en = 1'b1;
      end
      ST_SHIFT_RD: begin
        if (sts.more)              cmd.rd_en   = 1'b1;
        else if (sts.op == OP_REM) cmd.cnt_dec = 1'b1;
      end
      ST_SHIFT_WR: begin
        cmd.wr_en    = 1'b1;
        cmd.idx_step = 1'b1;
      end
      ST_PUT: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_item = 1'b1;
        cmd.cnt_inc = (sts.op == OP_INS);
      end
      ST_SRCH_RD: begin
        // index has reached the count when nothing matched
        if (sts.more) cmd.rd_en     = 1'b1;
        else          cmd.cap_found = 1'b1;
      end
      ST_SRCH_CMP: begin
        if (sts.hit) cmd.cap_found = 1'b1;
        else         cmd.idx_step  = 1'b1;
      end
      ST_RD_WAIT: cmd.cap_read = 1'b1;
      ST_FINISH:  cmd.out_load = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: sv/indexed_array_list.sv
`timescale 1ns / 1ps
// Insert at p shifts the entries from p onward up by one, remove at p shifts those past p
// down by one, search reads from the front until a match or the end, and a read of an
// empty list skips the RAM. Throughput: one request at a time; the next is taken once the
// result is in the output register. Shifts and searches move one entry at a time through
// the list RAM (a registered read, then one write or compare).
// Reset: entry count cleared, list contents undefined until written, no clearing pass.
module indexed_array_list import ial_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ial_req_if.sink   req,
  ial_rsp_if.source rsp
);

  ial_cmd_t cmd;
  ial_sts_t sts;

  ial_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ial_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .req_type   (req.req_type),
    .position   (req.position),
    .item_value (req.item_value),
    .rsp        (rsp)
  );

endmodule

FILE: bench/list_checker.sv
`timescale 1ns / 1ps

module list_checker import ial_pkg::*; (
  input  logic clk,
  input  logic rst,
  ial_req_if   req,
  ial_rsp_if   rsp,
  output int   errors,
  output int   pending,
  output int   level,
  output int   checked,
  output int   full_seen,
  output int   empty_seen
);

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] read_value;
    logic [POS_W-1:0]  found_position;
    logic [CNT_W-1:0]  count;
    logic              is_empty;
    logic              is_full;
  } list_result_t;

  list_result_t      want_q[$];
  list_result_t      next_want;
  logic [DATA_W-1:0] entries [DEPTH];
  int                fill;

  task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                               input logic [DATA_W-1:0] want);
    $display("%0t ns mismatch: %s got %0h want %0h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic put_entry(input int pos, input logic [DATA_W-1:0] val);
    if (fill >= DEPTH || pos > fill) return 1'b0;
    for (int i = fill; i > pos; i--) entries[i] = entries[i-1];
    entries[pos] = val;
    fill++;
    return 1'b1;
  endfunction

  function automatic logic take_entry(input int pos);
    if (fill == 0 || pos >= fill) return 1'b0;
    for (int i = pos; i + 1 < fill; i++) entries[i] = entries[i+1];
    fill--;
    return 1'b1;
  endfunction

  function automatic list_result_t apply_request(input logic [REQ_W-1:0] kind,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [DATA_W-1:0] val);
    list_result_t r;
    int           p;
    r = '0;
    p = int'(pos);
    case (kind)
      REQ_INSERT_AT:    r.ok = put_entry(p, val);
      REQ_INSERT_FRONT: r.ok = put_entry(0, val);
      REQ_INSERT_BACK:  r.ok = put_entry(fill, val);
      REQ_REMOVE_AT:    r.ok = take_entry(p);
      REQ_REMOVE_FRONT: r.ok = take_entry(0);
      REQ_REMOVE_BACK:  r.ok = (fill != 0) ? take_entry(fill - 1) : 1'b0;
      REQ_SEARCH: begin
        r.found_position = POS_W'(fill);
        for (int i = 0; i < fill; i++) begin
          if (entries[i] == val) begin
            r.found_position = POS_W'(i);
            break;
          end
        end
      end
      REQ_READ: begin
        // past the end falls back to the last entry
        if (p < fill) r.read_value = entries[p];
        else if (fill != 0) r.read_value = entries[fill-1];
      end
      REQ_OVERWRITE: begin
        if (p < fill) begin
          entries[p] = val;
          r.ok = 1'b1;
        end
      end
      default: ;
    endcase
    r.count    = CNT_W'(fill);
    r.is_empty = (fill == 0);
    r.is_full  = (fill == DEPTH);
    return r;
  endfunction

  task automatic compare_result(input list_result_t want);
    if (rsp.ok !== want.ok) flag_mismatch("ok", rsp.ok, want.ok);
    if (rsp.read_value !== want.read_value)
      flag_mismatch("read_value", rsp.read_value, want.read_value);
    if (rsp.found_position !== want.found_position)
      flag_mismatch("found_position", rsp.found_position, want.found_position);
    if (rsp.count !== want.count) flag_mismatch("count", rsp.count, want.count);
    if (rsp.is_empty !== want.is_empty) flag_mismatch("is_empty", rsp.is_empty, want.is_empty);
    if (rsp.is_full !== want.is_full) flag_mismatch("is_full", rsp.is_full, want.is_full);
  endtask

  // responses are matched before the new request is queued, so a result
  // arriving in the same cycle as its own request counts as unexpected
  always @(posedge clk) begin
    if (rst) begin
      fill = 0;
      want_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (want_q.size() == 0) begin
          flag_mismatch("result with nothing pending, count", rsp.count, '0);
        end else begin
          compare_result(want_q.pop_front());
          checked++;
        end
      end
      if (req.valid && req.ready) begin
        next_want = apply_request(req.req_type, req.position, req.item_value);
        want_q.push_back(next_want);
        if (next_want.is_full) full_seen++;
        if (next_want.is_empty) empty_seen++;
      end
    end
    pending = want_q.size();
    level   = fill;
  end

endmodule

FILE: bench/tb_indexed_array_list.sv
`timescale 1ns / 1ps

module tb_indexed_array_list;
  import ial_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = REQ_OVERWRITE + 1'b1;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = '1;
  localparam logic [REQ_W-1:0] INSERTS [3] = '{REQ_INSERT_AT, REQ_INSERT_FRONT,
                                               REQ_INSERT_BACK};
  localparam logic [REQ_W-1:0] REMOVES [3] = '{REQ_REMOVE_AT, REQ_REMOVE_FRONT,
                                               REQ_REMOVE_BACK};
  // small value pool so searches hit and duplicates exist
  localparam logic [DATA_W-1:0] POOL [6] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                                             32'h8000_0000, 32'hDEAD_BEEF, 32'h1234_5678};
  localparam int TAIL_CYCLES = 200;

  logic clk;
  logic rst;
  int   errors, pending, level, checked, full_seen, empty_seen;
  int   src_idle, snk_idle;
  int   sent;

  ial_req_if req_ch ();
  ial_rsp_if rsp_ch ();

  indexed_array_list uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  list_checker chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .errors     (errors),
    .pending    (pending),
    .level      (level),
    .checked    (checked),
    .full_seen  (full_seen),
    .empty_seen (empty_seen)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rsp_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                              input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < src_idle) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.position   <= pos;
    req_ch.item_value <= val;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // grow favors inserts, otherwise removes dominate; the rest is mixed
  task automatic random_request(input bit grow);
    int                r;
    logic [REQ_W-1:0]  kind;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    r = $urandom_range(99);
    if (r < 42)      kind = grow ? INSERTS[$urandom_range(2)] : REMOVES[$urandom_range(2)];
    else if (r < 54) kind = grow ? REMOVES[$urandom_range(2)] : INSERTS[$urandom_range(2)];
    else if (r < 66) kind = REQ_SEARCH;
    else if (r < 78) kind = REQ_READ;
    else if (r < 92) kind = REQ_OVERWRITE;
    else             kind = REQ_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
    r = $urandom_range(9);
    if (r < 7)      pos = POS_W'($urandom_range(level));
    else if (r < 9) pos = POS_W'($urandom_range(DEPTH));
    else            pos = POS_W'($urandom());
    val = ($urandom_range(9) < 4) ? POOL[$urandom_range(5)] : $urandom();
    send_request(kind, pos, val);
  endtask

  task automatic random_phase(input int items);
    int  left;
    bit  grow;
    grow = 1'b1;
    left = $urandom_range(80, 220);
    repeat (items) begin
      if (left == 0) begin
        grow = !grow;
        left = grow ? $urandom_range(120, 240) : $urandom_range(60, 160);
      end
      random_request(grow);
      left--;
    end
  endtask

  initial begin
    rst               <= 1'b1;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_INSERT_AT;
    req_ch.position   <= '0;
    req_ch.item_value <= '0;
    src_idle = 9;
    snk_idle = 76;
    sent     = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list corner cases
    send_request(REQ_REMOVE_FRONT, 7'd0, 32'h0);
    send_request(REQ_REMOVE_BACK, 7'd0, 32'h0);
    send_request(REQ_REMOVE_AT, 7'd0, 32'h0);
    send_request(REQ_READ, 7'd0, 32'h0);
    send_request(REQ_SEARCH, 7'd0, 32'h0);
    send_request(REQ_OVERWRITE, 7'd0, 32'hFFFF_FFFF);
    // build a short list, including an insert past the end
    send_request(REQ_INSERT_BACK, 7'd0, 32'hFFFF_FFFF);
    send_request(REQ_INSERT_FRONT, 7'd127, 32'h0000_0000);
    send_request(REQ_INSERT_AT, 7'd1, 32'hA5A5_A5A5);
    send_request(REQ_INSERT_AT, 7'd127, 32'h1111_1111);
    send_request(REQ_INSERT_AT, 7'd3, 32'h5A5A_5A5A);
    send_request(REQ_SEARCH, 7'd0, 32'hFFFF_FFFF);
    send_request(REQ_SEARCH, 7'd0, 32'h1234_5678);
    send_request(REQ_READ, 7'd1, 32'h0);
    send_request(REQ_READ, 7'd127, 32'h0);
    send_request(REQ_OVERWRITE, 7'd0, 32'h8000_0001);
    send_request(REQ_OVERWRITE, 7'd4, 32'h7FFF_FFFE);
    send_request(REQ_REMOVE_AT, 7'd2, 32'h0);
    send_request(REQ_REMOVE_AT, 7'd127, 32'h0);
    send_request(REQ_REMOVE_BACK, 7'd0, 32'h0);
    send_request(REQ_REMOVE_FRONT, 7'd0, 32'h0);
    send_request(REQ_UNUSED_LO, 7'd0, 32'h0);
    send_request(REQ_UNUSED_HI, 7'd127, 32'hFFFF_FFFF);
    send_request(REQ_REMOVE_AT, 7'd0, 32'h0);
    hold_until_drained();

    random_phase(320);
    hold_until_drained();
    src_idle = 76;
    snk_idle = 9;
    random_phase(320);
    hold_until_drained();
    src_idle = 0;
    snk_idle = 0;
    random_phase(310);

    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d requests sent over three idle mixes, %0d results checked", sent, checked);
    $display("list reported full %0d times and empty %0d times", full_seen, empty_seen);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/ial_pkg.sv
sv/ial_req_if.sv
sv/ial_rsp_if.sv
sv/ial_ram.sv
sv/ial_datapath.sv
sv/ial_ctrl.sv
sv/indexed_array_list.sv
bench/list_checker.sv
bench/tb_indexed_array_list.sv
